>>> rtl/iup_pkg.sv
// Shared constants, codes and item types of the integer pixel upscaler.
package iup_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_SCALE  = 63;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SCALE_W    = 6;
  localparam int WIDTH_W    = 12;
  localparam int PIX_W      = 24;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Input item kinds.
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REPLAY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [WIDTH_W-1:0] width;
  } iup_cfg_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [SCALE_W-1:0] count;
    logic               row_done;
    logic [1:0]         pad;
    logic               err;
  } iup_cmd_t;

  // One result item.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_padding;
    logic [1:0]       pad_bytes;
    logic             row_end;
    logic             last;
    logic             error;
  } iup_res_t;

endpackage

>>> rtl/iup_front.sv
// Front end: phase check, line store access and row bookkeeping.
module iup_front
  import iup_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iup_cfg_t         cfg_i,
  input  logic             push,
  output logic             full,
  input  logic             kind_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  output logic             cmd_push_o,
  output iup_cmd_t         cmd_o,
  input  logic             cmd_full_i
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [SCALE_W-1:0] rep_q, rep_d;
  logic               st_vld_q, st_vld_d;
  iup_cmd_t           st_q;
  logic               st_mem_q;
  logic [PIX_W-1:0]   rdata_q;
  logic [PIX_W-1:0]   mem [MAX_WIDTH];

  logic               accept;
  logic               want;
  logic               mismatch;
  logic [COL_W:0]     col_inc;
  logic               row_done;
  logic [1:0]         pad;
  logic               wr_en;
  logic               rd_en;
  iup_cmd_t           new_cmd;

  assign accept   = push && !full;
  assign want     = (rep_q != '0) ? KIND_REPLAY : KIND_PIXEL;
  assign mismatch = (kind_i != want);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_done = (WIDTH_W'(col_inc) >= cfg_i.width);
  assign pad      = 2'(cfg_i.width[1:0] * cfg_i.scale[1:0]);
  assign wr_en    = accept && !mismatch && (kind_i == KIND_PIXEL);
  assign rd_en    = accept && !mismatch && (kind_i == KIND_REPLAY);

  always_comb begin
    new_cmd = '0;
    if (mismatch) begin
      new_cmd.err = 1'b1;
    end else begin
      new_cmd.pixel    = pixel_in_i;
      new_cmd.count    = cfg_i.scale;
      new_cmd.row_done = row_done;
      new_cmd.pad      = row_done ? pad : 2'b00;
    end
  end

  always_comb begin
    col_d = col_q;
    rep_d = rep_q;
    if (accept && !mismatch) begin
      if (row_done) begin
        col_d = '0;
        if (kind_i == KIND_PIXEL) begin
          rep_d = cfg_i.scale - 1'b1;
        end else begin
          rep_d = rep_q - 1'b1;
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  // The stage holds one classified item until the queue takes it.
  always_comb begin
    st_vld_d = st_vld_q;
    if (accept) begin
      st_vld_d = 1'b1;
    end else if (st_vld_q && !cmd_full_i) begin
      st_vld_d = 1'b0;
    end
  end

  assign full       = st_vld_q && cmd_full_i;
  assign cmd_push_o = st_vld_q && !cmd_full_i;

  always_comb begin
    cmd_o = st_q;
    if (st_mem_q) begin
      cmd_o.pixel = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      rep_q    <= '0;
      st_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      rep_q    <= rep_d;
      st_vld_q <= st_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q     <= new_cmd;
      st_mem_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[col_q] <= pixel_in_i;
    end
    if (rd_en) begin
      rdata_q <= mem[col_q];
    end
  end

endmodule

>>> rtl/iup_cmdq.sv
// Short queue of classified items between the front and back ends.
module iup_cmdq
  import iup_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  iup_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output iup_cmd_t data_o,
  output logic     empty_o
);

  iup_cmd_t              entry_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [CMDQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [CMDQ_PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("item pushed into full command queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("item popped from empty command queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (CMDQ_PTR_W+1)'(CMDQ_DEPTH)) else $error("command queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("command queue count did not follow a push");
`endif

endmodule

>>> rtl/iup_back.sv
// Back end: expands each classified item into its result items.
module iup_back
  import iup_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  iup_cmd_t cmd_i,
  input  logic     cmd_empty_i,
  output logic     cmd_pop_o,
  output logic     empty,
  input  logic     pop,
  output iup_res_t res_o
);

  iup_cmd_t           cur_q;
  logic               busy_q, busy_d;
  logic [SCALE_W-1:0] cnt_q, cnt_d;
  logic               out_vld_q;
  iup_res_t           res_q;
  iup_res_t           emit;
  logic               done;
  logic               adv;

  assign adv       = !out_vld_q || pop;
  assign cmd_pop_o = !busy_q && !cmd_empty_i;
  assign empty     = !out_vld_q;
  assign res_o     = res_q;

  // Pixel copies first, then the padding result when the row closes; an error item gives a lone error result.
  always_comb begin
    emit = '0;
    done = 1'b0;
    if (cur_q.err) begin
      emit.last  = 1'b1;
      emit.error = 1'b1;
      done       = 1'b1;
    end else if (cnt_q != '0) begin
      emit.pixel = cur_q.pixel;
      emit.last  = !cur_q.row_done && (cnt_q == SCALE_W'(1));
      done       = emit.last;
    end else begin
      emit.is_padding = 1'b1;
      emit.pad_bytes  = cur_q.pad;
      emit.row_end    = 1'b1;
      emit.last       = 1'b1;
      done            = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (!busy_q) begin
      busy_d = !cmd_empty_i;
      if (!cmd_empty_i) begin
        cnt_d = cmd_i.count;
      end
    end else if (adv) begin
      if (done) begin
        busy_d = 1'b0;
      end
      if (!cur_q.err && (cnt_q != '0)) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (adv) begin
        out_vld_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (adv && busy_q) begin
      res_q <= emit;
    end
  end

endmodule

>>> rtl/integer_pixel_upscaler_core.sv
// Top level of the nearest neighbor integer pixel upscaler.
// An accepted item passes the front end's stage register, the command queue and the back
// end's item register; the back end gives one result per cycle while the receiver keeps
// popping, and takes a new item only once it has finished the last one.
// Reset clears the configuration to scale 1 and width 1, and the row position, replay
// count and all queues to empty; the line store keeps its contents and needs no clearing.
module integer_pixel_upscaler_core
  import iup_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [WIDTH_W-1:0] cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [PIX_W-1:0]   pixel_in_i,
  output logic               empty,
  input  logic               pop,
  output logic [PIX_W-1:0]   pixel_out_o,
  output logic               is_padding_o,
  output logic [1:0]         pad_bytes_o,
  output logic               row_end_o,
  output logic               last_o,
  output logic               error_o
);

  logic [SCALE_W-1:0] scale_q;
  logic [WIDTH_W-1:0] width_q;
  iup_cfg_t           cfg;
  logic               cmd_push;
  logic               cmd_pop;
  logic               cmd_full;
  logic               cmd_empty;
  iup_cmd_t           cmd_in;
  iup_cmd_t           cmd_out;
  iup_res_t           res;

  // Configuration registers hold the raw written values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      width_q <= WIDTH_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH: width_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // A zero scale or width acts as one; values above the maximum saturate.
  always_comb begin
    cfg.scale = scale_q;
    if (scale_q == '0) begin
      cfg.scale = SCALE_W'(1);
    end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end
    cfg.width = width_q;
    if (width_q == '0) begin
      cfg.width = WIDTH_W'(1);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      cfg.width = WIDTH_W'(MAX_WIDTH);
    end
  end

  // The front end checks each item against the phase and reads or fills the line store.
  iup_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .pixel_in_i (pixel_in_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // The queue lets the front end take new items while the back end is still expanding.
  iup_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // The back end emits the copies, padding and error results through its output register.
  iup_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign pixel_out_o  = res.pixel;
  assign is_padding_o = res.is_padding;
  assign pad_bytes_o  = res.pad_bytes;
  assign row_end_o    = res.row_end;
  assign last_o       = res.last;
  assign error_o      = res.error;

endmodule

>>> tb/tb_integer_pixel_upscaler_core.sv
// Self-checking testbench for the integer pixel upscaler core.
`timescale 1ns / 1ps

module tb_integer_pixel_upscaler_core;
  import iup_pkg::*;

  // Run control. The limit allows for every item expanding to 64 results under the slowest
  // drain pattern.
  localparam int unsigned CYCLE_LIMIT   = 800_000;
  localparam int unsigned RANDOM_ITEMS  = 200;
  // Settle time that covers the path from an accepted item to its first result.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int          DIR_ROWS      = 24;

  // Results that can be written down without working through the predictor.
  localparam iup_res_t NO_RESULT = '0;
  localparam iup_res_t ERR_RESULT = '{pixel: '0, is_padding: 1'b0, pad_bytes: 2'd0,
                                      row_end: 1'b0, last: 1'b1, error: 1'b1};
  localparam iup_res_t PAD_ONE_RESULT = '{pixel: '0, is_padding: 1'b1, pad_bytes: 2'd1,
                                          row_end: 1'b1, last: 1'b1, error: 1'b0};
  localparam iup_res_t WHITE_RESULT = '{pixel: 24'hFFFFFF, is_padding: 1'b0, pad_bytes: 2'd0,
                                        row_end: 1'b0, last: 1'b0, error: 1'b0};
  localparam iup_res_t BLACK_RESULT = '0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_COIN, DRAIN_PERIODIC, DRAIN_SLOW} drain_mode_e;

  // One row of the directed table: either an item or a register write. Rows with
  // n_lit above zero carry their expected results; all others go through the predictor.
  typedef struct {
    row_op_e     op;
    logic        sel;
    logic [23:0] data;
    int          n_lit;
    iup_res_t    lit0;
    iup_res_t    lit1;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [WIDTH_W-1:0] cfg_data_i;
  logic               push;
  logic               full;
  logic               kind_i;
  logic [PIX_W-1:0]   pixel_in_i;
  logic               empty;
  logic               pop;
  logic [PIX_W-1:0]   pixel_out_o;
  logic               is_padding_o;
  logic [1:0]         pad_bytes_o;
  logic               row_end_o;
  logic               last_o;
  logic               error_o;

  integer_pixel_upscaler_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .pixel_in_i   (pixel_in_i),
    .empty        (empty),
    .pop          (pop),
    .pixel_out_o  (pixel_out_o),
    .is_padding_o (is_padding_o),
    .pad_bytes_o  (pad_bytes_o),
    .row_end_o    (row_end_o),
    .last_o       (last_o),
    .error_o      (error_o)
  );

  // Predictor state: its own copy of the registers, the line store and the row position.
  logic [SCALE_W-1:0] cfg_scale_q;
  logic [WIDTH_W-1:0] cfg_width_q;
  logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
  int unsigned        col_q;
  logic [SCALE_W-1:0] replays_q;
  // Writes always start at column zero, so the written part of the line store is a
  // prefix of this length. Replays must never read beyond it.
  int unsigned        filled_q;

  // Results the block still owes, oldest first.
  iup_res_t           pending_results[$];

  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        cycles;
  int unsigned        burst_left;
  drain_mode_e        drain_mode;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Clamping of the raw register values, as the block applies it.
  function automatic int unsigned eff_scale(logic [SCALE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_SCALE) return MAX_SCALE;
    return raw;
  endfunction

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  // Works out the results of one accepted item and advances the predictor state.
  // With record low the state still moves but the results come from the table.
  task automatic upscale_predict(input logic k, input logic [PIX_W-1:0] p, input bit record);
    int unsigned    s;
    int unsigned    w;
    logic [PIX_W-1:0] px;
    bit             done;
    iup_res_t       r;
    s = eff_scale(cfg_scale_q);
    w = eff_width(cfg_width_q);
    // The block wants replay steps while replay rows are owed, and pixels otherwise.
    // An item of the other kind is answered with a lone error result.
    if (k != ((replays_q != '0) ? KIND_REPLAY : KIND_PIXEL)) begin
      if (record) pending_results.push_back(ERR_RESULT);
      return;
    end
    if (k == KIND_PIXEL) begin
      line_mem[col_q] = p;
      px = p;
      if (col_q >= filled_q) filled_q = col_q + 1;
    end else begin
      px = line_mem[col_q];
    end
    col_q++;
    // A width lowered mid-row closes the row as soon as the column reaches it.
    done = (col_q >= w);
    for (int i = 0; i < s; i++) begin
      r = '0;
      r.pixel = px;
      r.last = !done && (i == s - 1);
      if (record) pending_results.push_back(r);
    end
    if (done) begin
      r = '0;
      r.is_padding = 1'b1;
      r.pad_bytes = 2'(w * s);
      r.row_end = 1'b1;
      r.last = 1'b1;
      if (record) pending_results.push_back(r);
      col_q = 0;
      // A scale change during a replay leaves the loaded count alone.
      replays_q = (k == KIND_PIXEL) ? SCALE_W'(s - 1) : replays_q - 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                             input logic [PIX_W-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Offers one item, holds it until the block takes it, then records what it owes.
  // The sender works in bursts; a gap follows when a burst runs out.
  task automatic send_item(input logic k, input logic [PIX_W-1:0] p, input int n_lit,
                           input iup_res_t lit0, input iup_res_t lit1);
    int unsigned gap;
    push <= 1'b1;
    kind_i <= k;
    pixel_in_i <= p;
    do @(posedge clk_i); while (full);
    upscale_predict(k, p, n_lit == 0);
    if (n_lit > 0) pending_results.push_back(lit0);
    if (n_lit > 1) pending_results.push_back(lit1);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering items and waits until every owed result has been taken, then a
  // little longer so the block is surely idle.
  task automatic wait_idle();
    if (push) push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic cfg_write(input logic idx, input logic [WIDTH_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_SCALE) cfg_scale_q = value[SCALE_W-1:0];
    else cfg_width_q = value;
  endtask

  initial begin : stimulus
    dir_row_t         dir_tab [DIR_ROWS];
    int unsigned      random_items;
    int unsigned      n;
    int unsigned      pick;
    logic             k;
    logic [WIDTH_W-1:0] sdata;
    logic [WIDTH_W-1:0] wdata;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SCALE;
    cfg_data_i = '0;
    push = 1'b0;
    kind_i = KIND_PIXEL;
    pixel_in_i = '0;
    mismatches = 0;
    results_seen = 0;
    burst_left = 0;
    random_items = 0;
    cfg_scale_q = 1;
    cfg_width_q = 1;
    col_q = 0;
    replays_q = '0;
    filled_q = 0;

    // After reset: scale 1, width 1, so each pixel closes its own row.
    dir_tab[0]  = '{ROW_ITEM, KIND_REPLAY, 24'h000000, 1, ERR_RESULT, NO_RESULT};
    dir_tab[1]  = '{ROW_ITEM, KIND_PIXEL, 24'hFFFFFF, 2, WHITE_RESULT, PAD_ONE_RESULT};
    dir_tab[2]  = '{ROW_ITEM, KIND_PIXEL, 24'h000000, 2, BLACK_RESULT, PAD_ONE_RESULT};
    // Two-pixel rows at scale 3, then a scale of zero written in the middle of a replay.
    dir_tab[3]  = '{ROW_CFG, CFG_SCALE, 24'd3, 0, NO_RESULT, NO_RESULT};
    dir_tab[4]  = '{ROW_CFG, CFG_WIDTH, 24'd2, 0, NO_RESULT, NO_RESULT};
    dir_tab[5]  = '{ROW_ITEM, KIND_PIXEL, 24'h123456, 0, NO_RESULT, NO_RESULT};
    dir_tab[6]  = '{ROW_ITEM, KIND_PIXEL, 24'hFEDCBA, 0, NO_RESULT, NO_RESULT};
    dir_tab[7]  = '{ROW_ITEM, KIND_PIXEL, 24'h5A5A5A, 1, ERR_RESULT, NO_RESULT};
    dir_tab[8]  = '{ROW_ITEM, KIND_REPLAY, 24'h000000, 0, NO_RESULT, NO_RESULT};
    dir_tab[9]  = '{ROW_ITEM, KIND_REPLAY, 24'hFFFFFF, 0, NO_RESULT, NO_RESULT};
    dir_tab[10] = '{ROW_CFG, CFG_SCALE, 24'd0, 0, NO_RESULT, NO_RESULT};
    dir_tab[11] = '{ROW_ITEM, KIND_REPLAY, 24'hA5A5A5, 0, NO_RESULT, NO_RESULT};
    dir_tab[12] = '{ROW_ITEM, KIND_REPLAY, 24'h5A5A5A, 0, NO_RESULT, NO_RESULT};
    dir_tab[13] = '{ROW_ITEM, KIND_REPLAY, 24'h000000, 1, ERR_RESULT, NO_RESULT};
    // Width above the maximum and the largest scale, with unused data bits set.
    dir_tab[14] = '{ROW_CFG, CFG_WIDTH, 24'hFFF, 0, NO_RESULT, NO_RESULT};
    dir_tab[15] = '{ROW_CFG, CFG_SCALE, 24'hFFF, 0, NO_RESULT, NO_RESULT};
    dir_tab[16] = '{ROW_ITEM, KIND_PIXEL, 24'h800001, 0, NO_RESULT, NO_RESULT};
    dir_tab[17] = '{ROW_ITEM, KIND_PIXEL, 24'h7FFFFE, 0, NO_RESULT, NO_RESULT};
    // Width zero mid-row: the next pixel closes the row at once.
    dir_tab[18] = '{ROW_CFG, CFG_WIDTH, 24'd0, 0, NO_RESULT, NO_RESULT};
    dir_tab[19] = '{ROW_ITEM, KIND_PIXEL, 24'h0F0F0F, 0, NO_RESULT, NO_RESULT};
    dir_tab[20] = '{ROW_ITEM, KIND_REPLAY, 24'h000000, 0, NO_RESULT, NO_RESULT};
    // Raised during a replay, but only over columns that were already written.
    dir_tab[21] = '{ROW_CFG, CFG_WIDTH, 24'd3, 0, NO_RESULT, NO_RESULT};
    dir_tab[22] = '{ROW_ITEM, KIND_REPLAY, 24'hFFFFFF, 0, NO_RESULT, NO_RESULT};
    dir_tab[23] = '{ROW_ITEM, KIND_PIXEL, 24'hFFFFFF, 1, ERR_RESULT, NO_RESULT};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register writes only land while the block is idle.
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (dir_tab[row].op == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_tab[row].sel, dir_tab[row].data[WIDTH_W-1:0]);
        cfg_we_i <= 1'b0;
      end else begin
        send_item(dir_tab[row].sel, dir_tab[row].data, dir_tab[row].n_lit,
                  dir_tab[row].lit0, dir_tab[row].lit1);
      end
    end

    // Random phases. Each starts from an idle block with a fresh setting; most items
    // are the kind the block wants, so rows and replays run to completion, and about
    // one in ten is the wrong kind.
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 7);
      case (pick)
        0: sdata = {6'($urandom), 6'd0};
        1: sdata = {6'($urandom), 6'(MAX_SCALE)};
        2: sdata = {6'($urandom), 6'd1};
        default: sdata = {6'($urandom), 6'($urandom_range(2, 6))};
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0: wdata = '0;
        1: wdata = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 4095));
        2: wdata = WIDTH_W'(MAX_WIDTH);
        default: wdata = WIDTH_W'($urandom_range(1, 7));
      endcase
      // While replays are owed, a wider row would read columns never written.
      if (replays_q != '0 && eff_width(wdata) > filled_q) begin
        wdata = WIDTH_W'($urandom_range(1, filled_q));
      end
      cfg_write(CFG_SCALE, sdata);
      cfg_write(CFG_WIDTH, wdata);
      cfg_we_i <= 1'b0;
      n = $urandom_range(8, 30);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      repeat (n) begin
        k = (replays_q != '0) ? KIND_REPLAY : KIND_PIXEL;
        if ($urandom_range(0, 9) == 0) k = ~k;
        send_item(k, PIX_W'($urandom), 0, NO_RESULT, NO_RESULT);
        random_items++;
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The receiver switches between drain patterns: always ready, a coin toss, a fixed duty
  // cycle, or mostly stalled.
  always @(posedge clk_i) begin
    if (cycles % 150 == 0) drain_mode = drain_mode_e'($urandom_range(0, 3));
    case (drain_mode)
      DRAIN_FREE:     pop <= 1'b1;
      DRAIN_COIN:     pop <= 1'($urandom_range(0, 1));
      DRAIN_PERIODIC: pop <= (cycles % 7) >= 3;
      default:        pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial pop = 1'b0;

  // Every result item taken is compared with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    iup_res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result item arrived with nothing owed");
      end else begin
        want = pending_results.pop_front();
        check_field("pixel_out", pixel_out_o, want.pixel);
        check_field("is_padding", PIX_W'(is_padding_o), PIX_W'(want.is_padding));
        check_field("pad_bytes", PIX_W'(pad_bytes_o), PIX_W'(want.pad_bytes));
        check_field("row_end", PIX_W'(row_end_o), PIX_W'(want.row_end));
        check_field("last", PIX_W'(last_o), PIX_W'(want.last));
        check_field("error", PIX_W'(error_o), PIX_W'(want.error));
      end
      results_seen++;
    end
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

>>> integer_pixel_upscaler_core.f
rtl/iup_pkg.sv
rtl/iup_front.sv
rtl/iup_cmdq.sv
rtl/iup_back.sv
rtl/integer_pixel_upscaler_core.sv
tb/tb_integer_pixel_upscaler_core.sv
